// File: rtl/core/compass_heading_smoother_defines.svh
// assertion macros for the compass heading smoother rtl
`ifndef COMPASS_HEADING_SMOOTHER_DEFINES_SVH
`define COMPASS_HEADING_SMOOTHER_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold on every clock edge out of reset
`define CHS_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// condition that must never be seen
`define CHS_ASSERT_NEVER(label, cond) `CHS_ASSERT(label, !(cond))
`else
`define CHS_ASSERT(label, prop)
`define CHS_ASSERT_NEVER(label, cond)
`endif

`endif

// File: rtl/core/chs_pkg.sv
`timescale 1ns / 1ps

package chs_pkg;

    // default parameter values
    localparam int SAMPLE_BITS_DEF         = 16;
    localparam int ANGLE_FRACTION_BITS_DEF = 6;
    localparam int CORDIC_STEPS_DEF        = 16;

    // result field widths and packed output item
    localparam int OUT_W       = 15;
    localparam int OUT_TDATA_W = 48;

    // configuration registers
    localparam int GAIN_W      = 16;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_GAIN  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_GAIN = 1'b1;
    localparam logic [GAIN_W-1:0] SENSOR_GAIN_RESET  = 16'd11796;
    localparam logic [GAIN_W-1:0] DISPLAY_GAIN_RESET = 16'd22938;

    // cordic angle accumulator, degrees in q.16
    localparam int ANG_Q       = 16;
    localparam int Z_W         = 27;
    localparam int TABLE_LEN   = 24;
    localparam int TABLE_IDX_W = 5;
    localparam int ATAN_W      = 22;
    localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(180 * (1 << ANG_Q));
    localparam logic signed [Z_W-1:0] Z_FULL = Z_W'(360 * (1 << ANG_Q));

    // sign of the input vector, worked out in the front part
    typedef struct packed {
        logic zero_vec;
        logic left_half;
    } chs_class_t;

    // atan(2^-i) in q.16 degrees
    function automatic logic [ATAN_W-1:0] atan_step(input logic [TABLE_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        case (idx)
            5'd0:    val = 22'd2949120;
            5'd1:    val = 22'd1740967;
            5'd2:    val = 22'd919879;
            5'd3:    val = 22'd466945;
            5'd4:    val = 22'd234379;
            5'd5:    val = 22'd117304;
            5'd6:    val = 22'd58666;
            5'd7:    val = 22'd29335;
            5'd8:    val = 22'd14668;
            5'd9:    val = 22'd7334;
            5'd10:   val = 22'd3667;
            5'd11:   val = 22'd1833;
            5'd12:   val = 22'd917;
            5'd13:   val = 22'd458;
            5'd14:   val = 22'd229;
            5'd15:   val = 22'd115;
            5'd16:   val = 22'd57;
            5'd17:   val = 22'd29;
            5'd18:   val = 22'd14;
            5'd19:   val = 22'd7;
            5'd20:   val = 22'd4;
            5'd21:   val = 22'd2;
            5'd22:   val = 22'd1;
            default: val = 22'd0;
        endcase
        return val;
    endfunction

endpackage

// File: rtl/core/chs_front.sv
`timescale 1ns / 1ps

module chs_front #(
    parameter int SAMPLE_BITS = chs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic signed [SAMPLE_BITS-1:0] mag_x,
    input  logic signed [SAMPLE_BITS-1:0] mag_y,
    output logic                          job_valid,
    input  logic                          job_ready,
    output logic signed [SAMPLE_BITS+2:0] job_u,
    output logic signed [SAMPLE_BITS+2:0] job_v,
    output chs_pkg::chs_class_t           job_class
);

    localparam int CW = SAMPLE_BITS + 3;

    logic signed [CW-1:0] x_ext;
    logic signed [CW-1:0] y_ext;
    logic signed [CW-1:0] u_in;
    logic signed [CW-1:0] v_in;
    chs_pkg::chs_class_t  class_in;

    logic signed [CW-1:0] q_u_reg [2];
    logic signed [CW-1:0] q_v_reg [2];
    chs_pkg::chs_class_t  q_class_reg [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           cnt_reg;
    logic [1:0]           cnt_next;
    logic                 push;
    logic                 pop;

    // vector (-x, -y), turned by half a circle when it points left
    always_comb
    begin
        x_ext              = CW'(mag_x);
        y_ext              = CW'(mag_y);
        class_in.zero_vec  = (x_ext == '0) && (y_ext == '0);
        class_in.left_half = (x_ext > 0);
        if (class_in.left_half)
        begin
            u_in = x_ext;
            v_in = y_ext;
        end
        else
        begin
            u_in = -x_ext;
            v_in = -y_ext;
        end
    end

    // two entry queue towards the cordic
    assign s_tready  = (cnt_reg != 2'd2);
    assign job_valid = (cnt_reg != 2'd0);
    assign push      = s_tvalid && s_tready;
    assign pop       = job_valid && job_ready;
    assign job_u     = q_u_reg[rd_ptr_reg];
    assign job_v     = q_v_reg[rd_ptr_reg];
    assign job_class = q_class_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_u_reg[wr_ptr_reg]     <= u_in;
            q_v_reg[wr_ptr_reg]     <= v_in;
            q_class_reg[wr_ptr_reg] <= class_in;
        end
    end

endmodule

// File: rtl/core/chs_cordic.sv
`timescale 1ns / 1ps

module chs_cordic #(
    parameter int SAMPLE_BITS         = chs_pkg::SAMPLE_BITS_DEF,
    parameter int ANGLE_FRACTION_BITS = chs_pkg::ANGLE_FRACTION_BITS_DEF,
    parameter int CORDIC_STEPS        = chs_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  logic signed [SAMPLE_BITS+2:0] job_u,
    input  logic signed [SAMPLE_BITS+2:0] job_v,
    input  chs_pkg::chs_class_t           job_class,
    output logic                          raw_valid,
    input  logic                          raw_ready,
    output logic [$clog2(360 * (1 << ANGLE_FRACTION_BITS))-1:0] raw_heading
);

    localparam int CW       = SAMPLE_BITS + 3;
    localparam int ZW       = chs_pkg::Z_W;
    localparam int ANG_W    = $clog2(360 * (1 << ANGLE_FRACTION_BITS));
    localparam int OUT_FULL = 360 * (1 << ANGLE_FRACTION_BITS);
    localparam int RS       = chs_pkg::ANG_Q - ANGLE_FRACTION_BITS;
    localparam int STEPS    = (CORDIC_STEPS > chs_pkg::TABLE_LEN) ?
                              chs_pkg::TABLE_LEN : CORDIC_STEPS;
    localparam logic [chs_pkg::TABLE_IDX_W-1:0] LAST_STEP =
        chs_pkg::TABLE_IDX_W'(STEPS - 1);
    localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(1 << (RS - 1));
    localparam logic signed [ZW-1:0] FULL_OUT_Z = ZW'(OUT_FULL);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_WRAP  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]                         state_reg;
    logic [chs_pkg::TABLE_IDX_W-1:0]    step_reg;
    logic signed [CW-1:0]               u_reg;
    logic signed [CW-1:0]               v_reg;
    logic signed [ZW-1:0]               z_reg;
    logic [ANG_W-1:0]                   heading_reg;

    logic signed [CW-1:0]               du;
    logic signed [CW-1:0]               dv;
    logic signed [ZW-1:0]               dz;
    logic signed [ZW-1:0]               z_round;

    assign job_ready   = (state_reg == ST_IDLE);
    assign raw_valid   = (state_reg == ST_DONE);
    assign raw_heading = heading_reg;

    // one micro-rotation: floor shifts and the table angle for this step
    always_comb
    begin
        du      = v_reg >>> step_reg;
        dv      = u_reg >>> step_reg;
        dz      = ZW'($signed({1'b0, chs_pkg::atan_step(step_reg)}));
        z_round = (z_reg + ROUND_HALF) >>> RS;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (job_valid)
                    begin
                        state_reg <= job_class.zero_vec ? ST_DONE : ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= ST_WRAP;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_WRAP:  state_reg <= ST_ROUND;
                ST_ROUND: state_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (raw_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                u_reg       <= job_u;
                v_reg       <= job_v;
                z_reg       <= job_class.left_half ? chs_pkg::Z_HALF : '0;
                heading_reg <= ANG_W'(OUT_FULL / 2);
            end
            ST_RUN:
            begin
                if (v_reg < 0)
                begin
                    u_reg <= u_reg - du;
                    v_reg <= v_reg + dv;
                    z_reg <= z_reg - dz;
                end
                else
                begin
                    u_reg <= u_reg + du;
                    v_reg <= v_reg - dv;
                    z_reg <= z_reg + dz;
                end
            end
            ST_WRAP:
            begin
                if (z_reg < 0)
                begin
                    z_reg <= z_reg + chs_pkg::Z_FULL;
                end
                else if (z_reg >= chs_pkg::Z_FULL)
                begin
                    z_reg <= z_reg - chs_pkg::Z_FULL;
                end
            end
            ST_ROUND:
            begin
                if (z_round >= FULL_OUT_Z)
                begin
                    heading_reg <= ANG_W'(z_round - FULL_OUT_Z);
                end
                else
                begin
                    heading_reg <= ANG_W'(z_round);
                end
            end
            default:
            begin
                heading_reg <= heading_reg;
            end
        endcase
    end

endmodule

// File: rtl/core/chs_smooth.sv
`timescale 1ns / 1ps
`include "compass_heading_smoother_defines.svh"

module chs_smooth #(
    parameter int ANGLE_FRACTION_BITS = chs_pkg::ANGLE_FRACTION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [chs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [chs_pkg::GAIN_W-1:0]        cfg_data,
    input  logic                              raw_valid,
    output logic                              raw_ready,
    input  logic [$clog2(360 * (1 << ANGLE_FRACTION_BITS))-1:0] raw_heading,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [chs_pkg::OUT_W-1:0]         display_heading,
    output logic [chs_pkg::OUT_W-1:0]         filtered_heading,
    output logic [chs_pkg::OUT_W-1:0]         raw_heading_out
);

    localparam int OW       = chs_pkg::OUT_W;
    localparam int ANG_W    = $clog2(360 * (1 << ANGLE_FRACTION_BITS));
    localparam int HW       = (ANG_W > OW) ? ANG_W : OW;
    localparam int DW       = HW + 2;
    localparam int PW       = DW + chs_pkg::GAIN_W + 1;
    localparam int OUT_FULL = 360 * (1 << ANGLE_FRACTION_BITS);
    localparam logic signed [DW-1:0] FULL_D = DW'(OUT_FULL);
    localparam logic signed [DW-1:0] HALF_D = DW'(OUT_FULL / 2);
    localparam logic signed [PW-1:0] ROUND_P = PW'(1 << (chs_pkg::ANG_Q - 1));

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]                 state_reg;
    logic                       phase_reg;
    logic                       pending_reg;
    logic [chs_pkg::GAIN_W-1:0] sensor_gain_reg;
    logic [chs_pkg::GAIN_W-1:0] display_gain_reg;
    logic [OW-1:0]              s1_reg;
    logic [OW-1:0]              s2_reg;
    logic [OW-1:0]              raw_reg;
    logic [OW-1:0]              cur_reg;
    logic [HW-1:0]              tgt_reg;
    logic signed [PW-1:0]       prod_reg;
    logic                       m_tvalid_reg;
    logic [OW-1:0]              disp_out_reg;
    logic [OW-1:0]              filt_out_reg;
    logic [OW-1:0]              raw_out_reg;

    logic [HW-1:0]              raw_ext;
    logic signed [DW-1:0]       cur_d;
    logic signed [DW-1:0]       diff;
    logic signed [DW-1:0]       folded;
    logic [chs_pkg::GAIN_W-1:0] gain_sel;
    logic signed [PW-1:0]       prod_next;
    logic signed [PW-1:0]       step_p;
    logic signed [DW-1:0]       sum;
    logic signed [DW-1:0]       sum_wrap;
    logic [OW-1:0]              res;
    logic                       out_free;

    assign raw_ready        = (state_reg == ST_IDLE);
    assign m_tvalid         = m_tvalid_reg;
    assign display_heading  = disp_out_reg;
    assign filtered_heading = filt_out_reg;
    assign raw_heading_out  = raw_out_reg;
    assign out_free         = !m_tvalid_reg || m_tready;

    // fold the difference into half a circle each way and scale by the gain
    always_comb
    begin
        raw_ext  = HW'(raw_heading);
        cur_d    = $signed({{(DW - OW){1'b0}}, cur_reg});
        diff     = $signed({2'b00, tgt_reg}) - cur_d;
        folded   = diff;
        if (folded > HALF_D)
        begin
            folded = folded - FULL_D;
        end
        if (folded < -HALF_D)
        begin
            folded = folded + FULL_D;
        end
        gain_sel  = phase_reg ? display_gain_reg : sensor_gain_reg;
        prod_next = PW'(folded) * PW'($signed({1'b0, gain_sel}));
    end

    // round half up, add and wrap into one circle
    always_comb
    begin
        step_p   = (prod_reg + ROUND_P) >>> chs_pkg::ANG_Q;
        sum      = cur_d + step_p[DW-1:0];
        sum_wrap = sum;
        if (sum < 0)
        begin
            sum_wrap = sum + FULL_D;
        end
        else if (sum >= FULL_D)
        begin
            sum_wrap = sum - FULL_D;
        end
        res = sum_wrap[OW-1:0];
    end

    // gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_gain_reg  <= chs_pkg::SENSOR_GAIN_RESET;
            display_gain_reg <= chs_pkg::DISPLAY_GAIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                chs_pkg::REG_SENSOR_GAIN:  sensor_gain_reg  <= cfg_data;
                chs_pkg::REG_DISPLAY_GAIN: display_gain_reg <= cfg_data;
                default:                   sensor_gain_reg  <= sensor_gain_reg;
            endcase
        end
    end

    // control and smoother state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= 1'b0;
            pending_reg  <= 1'b1;
            s1_reg       <= '0;
            s2_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // output valid: set when the result is loaded, cleared when taken
            if (state_reg == ST_OUT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    phase_reg <= 1'b0;
                    if (raw_valid)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:  state_reg <= ST_ADD;
                ST_ADD:
                begin
                    if (!phase_reg)
                    begin
                        s1_reg    <= res;
                        phase_reg <= 1'b1;
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        s2_reg      <= res;
                        pending_reg <= 1'b0;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // working registers and output item
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                tgt_reg <= raw_ext;
                raw_reg <= raw_ext[OW-1:0];
                cur_reg <= pending_reg ? raw_ext[OW-1:0] : s1_reg;
            end
            ST_MUL:
            begin
                prod_reg <= prod_next;
            end
            ST_ADD:
            begin
                if (!phase_reg)
                begin
                    tgt_reg <= HW'(res);
                    cur_reg <= pending_reg ? raw_reg : s2_reg;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    disp_out_reg <= s2_reg;
                    filt_out_reg <= s1_reg;
                    raw_out_reg  <= raw_reg;
                end
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    // a sample taken from the cordic starts the first smoother
    `CHS_ASSERT(a_take_starts_first, (raw_valid && raw_ready) |=> (state_reg == ST_MUL && !phase_reg))
    // the second smoother always finishes into the output stage
    `CHS_ASSERT(a_second_add_to_out, (state_reg == ST_ADD && phase_reg) |=> (state_reg == ST_OUT))
    // the first-sample load is spent once a result is ready to leave
    `CHS_ASSERT_NEVER(a_out_with_pending, (state_reg == ST_OUT) && pending_reg)

endmodule

// File: rtl/core/compass_heading_smoother.sv
`timescale 1ns / 1ps

// channel   dir  handshake           payload
// s_axis    in   s_tvalid/s_tready   s_tdata: mag_x, mag_y
// m_axis    out  m_tvalid/m_tready   m_tdata: display, filtered, raw heading
// cfg       in   cfg_wr_en           cfg_index, cfg_data (gain registers)
//
// an item passes from input to output through the queue, the iterative cordic
// at one step per cycle, wrap, round, hand-over, a multiply and an add for
// each smoother on the shared smoother multiplier, and the output stage;
// the cordic takes a new item only once the last has left it; a zero vector skips the steps.
// rst_n is asynchronous; after reset the first item loads both smoothers.
// a stalled m_tready holds the result; the back then stalls and the queue fills.

module compass_heading_smoother #(
    parameter int SAMPLE_BITS         = chs_pkg::SAMPLE_BITS_DEF,
    parameter int ANGLE_FRACTION_BITS = chs_pkg::ANGLE_FRACTION_BITS_DEF,
    parameter int CORDIC_STEPS        = chs_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // mag_x, mag_y
    input  logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // display_heading, filtered_heading, raw_heading
    output logic [chs_pkg::OUT_TDATA_W-1:0]         m_tdata,
    input  logic                                    cfg_wr_en,
    input  logic [chs_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [chs_pkg::GAIN_W-1:0]              cfg_data
);

    localparam int CW    = SAMPLE_BITS + 3;
    localparam int ANG_W = $clog2(360 * (1 << ANGLE_FRACTION_BITS));
    localparam int PAD_W = chs_pkg::OUT_TDATA_W - 3 * chs_pkg::OUT_W;

    logic signed [SAMPLE_BITS-1:0] mag_x;
    logic signed [SAMPLE_BITS-1:0] mag_y;
    logic                          job_valid;
    logic                          job_ready;
    logic signed [CW-1:0]          job_u;
    logic signed [CW-1:0]          job_v;
    chs_pkg::chs_class_t           job_class;
    logic                          raw_valid;
    logic                          raw_ready;
    logic [ANG_W-1:0]              raw_heading;
    logic [chs_pkg::OUT_W-1:0]     display_heading;
    logic [chs_pkg::OUT_W-1:0]     filtered_heading;
    logic [chs_pkg::OUT_W-1:0]     raw_heading_out;

    // unpack and pack items
    assign mag_x   = s_tdata[SAMPLE_BITS-1:0];
    assign mag_y   = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign m_tdata = {{PAD_W{1'b0}}, raw_heading_out, filtered_heading, display_heading};

    // front: accept, classify, queue
    chs_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .mag_x     (mag_x),
        .mag_y     (mag_y),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_u     (job_u),
        .job_v     (job_v),
        .job_class (job_class)
    );

    // back: iterative cordic
    chs_cordic #(
        .SAMPLE_BITS         (SAMPLE_BITS),
        .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS),
        .CORDIC_STEPS        (CORDIC_STEPS)
    ) u_cordic (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job_u       (job_u),
        .job_v       (job_v),
        .job_class   (job_class),
        .raw_valid   (raw_valid),
        .raw_ready   (raw_ready),
        .raw_heading (raw_heading)
    );

    // back: two smoothers and output register
    chs_smooth #(
        .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
    ) u_smooth (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .raw_valid        (raw_valid),
        .raw_ready        (raw_ready),
        .raw_heading      (raw_heading),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .display_heading  (display_heading),
        .filtered_heading (filtered_heading),
        .raw_heading_out  (raw_heading_out)
    );

endmodule

// File: tb/compass_heading_smoother_tb.sv
`timescale 1ns / 1ps

module compass_heading_smoother_tb;

    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 40;
    localparam int PHASE_ITEMS  = 170;
    localparam int RAND_PHASES  = 6;
    localparam int MAX_REPORTS  = 10;

    // one result item split into its headings
    typedef struct packed {
        logic [chs_pkg::OUT_W-1:0] display_hdg;
        logic [chs_pkg::OUT_W-1:0] filtered_hdg;
        logic [chs_pkg::OUT_W-1:0] raw_hdg;
    } heading_t;

    // predicted headings and the queue of results still to come
    class heading_scoreboard;
        logic [chs_pkg::GAIN_W-1:0] sensor_gain;
        logic [chs_pkg::GAIN_W-1:0] display_gain;
        longint sensor_val;
        longint display_val;
        bit load_pending;
        longint atan_q16[24];
        longint turn_full;
        longint turn_half;
        int round_shift;
        int steps;
        heading_t pending_q[$];
        int failures;

        function new();
            sensor_gain  = chs_pkg::SENSOR_GAIN_RESET;
            display_gain = chs_pkg::DISPLAY_GAIN_RESET;
            sensor_val   = 0;
            display_val  = 0;
            load_pending = 1'b1;
            failures     = 0;
            atan_q16 = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                         14668, 7334, 3667, 1833, 917, 458, 229, 115,
                         57, 29, 14, 7, 4, 2, 1, 0};
            turn_full   = longint'(360) << chs_pkg::ANGLE_FRACTION_BITS_DEF;
            turn_half   = longint'(180) << chs_pkg::ANGLE_FRACTION_BITS_DEF;
            round_shift = chs_pkg::ANG_Q - chs_pkg::ANGLE_FRACTION_BITS_DEF;
            steps       = (chs_pkg::CORDIC_STEPS_DEF > 24) ? 24 : chs_pkg::CORDIC_STEPS_DEF;
        endfunction

        function void set_gain(logic [chs_pkg::CFG_INDEX_W-1:0] idx,
                               logic [chs_pkg::GAIN_W-1:0] value);
            if (idx == chs_pkg::REG_SENSOR_GAIN)
                sensor_gain = value;
            else if (idx == chs_pkg::REG_DISPLAY_GAIN)
                display_gain = value;
        endfunction

        // vectoring cordic, angle of (u, v) in output units within [0, turn_full)
        function longint vector_heading(longint u, longint v);
            longint z;
            longint du;
            longint dv;
            z = 0;
            if (u == 0 && v == 0)
                return turn_half;
            // left half plane: turn by 180 first
            if (u < 0)
            begin
                u = -u;
                v = -v;
                z = longint'(180) << chs_pkg::ANG_Q;
            end
            for (int i = 0; i < steps; i++)
            begin
                du = v >>> i;
                dv = u >>> i;
                if (v < 0)
                begin
                    u = u - du;
                    v = v + dv;
                    z = z - atan_q16[i];
                end
                else
                begin
                    u = u + du;
                    v = v - dv;
                    z = z + atan_q16[i];
                end
            end
            while (z < 0)
                z = z + (longint'(360) << chs_pkg::ANG_Q);
            while (z >= (longint'(360) << chs_pkg::ANG_Q))
                z = z - (longint'(360) << chs_pkg::ANG_Q);
            z = (z + (longint'(1) << (round_shift - 1))) >>> round_shift;
            if (z >= turn_full)
                z = z - turn_full;
            return z;
        endfunction

        // wrap-aware exponential step, difference folded only beyond +-180
        function longint ema_step(longint cur, longint target,
                                  logic [chs_pkg::GAIN_W-1:0] gain);
            longint d;
            d = target - cur;
            if (d > turn_half)
                d = d - turn_full;
            if (d < -turn_half)
                d = d + turn_full;
            cur = cur + ((d * longint'(gain) + 32768) >>> 16);
            if (cur < 0)
                cur = cur + turn_full;
            if (cur >= turn_full)
                cur = cur - turn_full;
            return cur & 'h7FFF;
        endfunction

        // accepted input item: x in the low half, y in the high half
        function void note_sample(logic [31:0] data);
            longint x;
            longint y;
            longint raw;
            heading_t exp_hdg;
            x = longint'($signed(data[15:0]));
            y = longint'($signed(data[31:16]));
            raw = vector_heading(-x, -y);
            if (load_pending)
            begin
                sensor_val   = raw & 'h7FFF;
                display_val  = raw & 'h7FFF;
                load_pending = 1'b0;
            end
            sensor_val  = ema_step(sensor_val, raw, sensor_gain);
            display_val = ema_step(display_val, sensor_val, display_gain);
            exp_hdg.display_hdg  = chs_pkg::OUT_W'(display_val);
            exp_hdg.filtered_hdg = chs_pkg::OUT_W'(sensor_val);
            exp_hdg.raw_hdg      = chs_pkg::OUT_W'(raw);
            pending_q.push_back(exp_hdg);
        endfunction

        // accepted result item against the oldest prediction
        function void check_heading(logic [chs_pkg::OUT_TDATA_W-1:0] data);
            heading_t got;
            heading_t exp_hdg;
            got.display_hdg  = data[chs_pkg::OUT_W-1:0];
            got.filtered_hdg = data[2*chs_pkg::OUT_W-1:chs_pkg::OUT_W];
            got.raw_hdg      = data[3*chs_pkg::OUT_W-1:2*chs_pkg::OUT_W];
            if (pending_q.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result: display %0d filtered %0d raw %0d",
                             got.display_hdg, got.filtered_hdg, got.raw_hdg);
                return;
            end
            exp_hdg = pending_q.pop_front();
            if (got != exp_hdg)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display({"mismatch: expected display %0d filtered %0d raw %0d, ",
                              "got display %0d filtered %0d raw %0d"},
                             exp_hdg.display_hdg, exp_hdg.filtered_hdg, exp_hdg.raw_hdg,
                             got.display_hdg, got.filtered_hdg, got.raw_hdg);
            end
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    // mag_x, mag_y
    logic [31:0]                        s_tdata;
    logic                               m_tvalid;
    logic                               m_tready;
    // display_heading, filtered_heading, raw_heading
    logic [chs_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic                               cfg_wr_en;
    logic [chs_pkg::CFG_INDEX_W-1:0]    cfg_index;
    logic [chs_pkg::GAIN_W-1:0]         cfg_data;

    bit stall_request;

    heading_scoreboard sb = new();

    compass_heading_smoother dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // handshakes seen at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_sample(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_heading(m_tdata);
    end

    // receiver: segments of periodic ready patterns, plus a long hold on request
    initial
    begin
        int period;
        int duty;
        int seg;
        int hold_left;
        m_tready = 1'b0;
        hold_left = 0;
        forever
        begin
            period = $urandom_range(1, 8);
            duty   = $urandom_range(1, period);
            seg    = $urandom_range(20, 200);
            for (int c = 0; c < seg; c++)
            begin
                @(negedge clk);
                if (stall_request)
                begin
                    stall_request = 1'b0;
                    hold_left = LONG_HOLD;
                end
                if (hold_left > 0)
                begin
                    hold_left--;
                    m_tready <= 1'b0;
                end
                else
                    m_tready <= ((c % period) < duty);
            end
        end
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic idle_for(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // stop sending and wait for every predicted result
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_gain(input logic [chs_pkg::CFG_INDEX_W-1:0] idx,
                              input logic [chs_pkg::GAIN_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.set_gain(idx, value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // random sample: full range, tiny vectors, steady heading across the wrap and near 180, extremes
    task automatic pick_sample(output logic signed [15:0] x, output logic signed [15:0] y);
        logic signed [15:0] corner[6];
        int kind;
        corner = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFF};
        kind = $urandom_range(0, 9);
        if (kind < 3)
        begin
            x = 16'($urandom);
            y = 16'($urandom);
        end
        else if (kind < 5)
        begin
            x = 16'($signed($urandom_range(0, 8)) - 4);
            y = 16'($signed($urandom_range(0, 8)) - 4);
        end
        else if (kind < 8)
        begin
            x = -16'($urandom_range(1000, 20000));
            y = 16'($signed($urandom_range(0, 600)) - 300);
        end
        else if (kind < 9)
        begin
            x = 16'($urandom_range(1000, 20000));
            y = 16'($signed($urandom_range(0, 600)) - 300);
        end
        else
        begin
            x = corner[$urandom_range(0, 5)];
            y = corner[$urandom_range(0, 5)];
        end
    endtask

    // stimulus
    initial
    begin
        logic signed [15:0] dir_x[24];
        logic signed [15:0] dir_y[24];
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [chs_pkg::GAIN_W-1:0] g_sensor[RAND_PHASES];
        logic [chs_pkg::GAIN_W-1:0] g_display[RAND_PHASES];
        int burst_left;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = chs_pkg::REG_SENSOR_GAIN;
        cfg_data      = '0;
        stall_request = 1'b0;

        // heading near zero loads both smoothers, then a zero vector is exactly 180 away
        dir_x = '{-16'sd1000, 16'sd0, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                  16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 16'sd1, -16'sd1,
                  16'sd0, 16'sd0, -16'sd1, 16'sd1, 16'sd1, -16'sd1,
                  16'sd0, 16'sd100, 16'sd100, -16'sd100, -16'sd100, -16'sd1000};
        dir_y = '{16'sd0, 16'sd0, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                  16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0,
                  16'sd1, -16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1,
                  16'sd0, -16'sd1, 16'sd1, 16'sd1, -16'sd1, 16'sd0};
        g_sensor  = '{16'd0, 16'hFFFF, chs_pkg::SENSOR_GAIN_RESET, 16'd1, 16'($urandom),
                      16'($urandom)};
        g_display = '{16'hFFFF, 16'd0, chs_pkg::DISPLAY_GAIN_RESET, 16'h8000, 16'($urandom),
                      16'($urandom)};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed items at the reset gains
        for (int i = 0; i < 24; i++)
            send_sample(dir_x[i], dir_y[i]);
        drain_results();

        // random phases, each with its own gains
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            write_gain(chs_pkg::REG_SENSOR_GAIN, g_sensor[p]);
            write_gain(chs_pkg::REG_DISPLAY_GAIN, g_display[p]);
            if (p == 2)
                stall_request = 1'b1;
            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (burst_left == 0)
                begin
                    idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                pick_sample(x, y);
                send_sample(x, y);
            end
            drain_results();
        end

        if (sb.outstanding() != 0)
        begin
            sb.failures += sb.outstanding();
            $display("%0d results never arrived", sb.outstanding());
        end
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
